/* hdl/acm_pkg.sv */
// Shared constants, node and result record types and a symbol helper for the Aho-Corasick matcher.
package acm_pkg;

  localparam int NODES    = 1024;
  localparam int ALPHABET = 4;
  localparam int NODE_W   = $clog2(NODES);
  localparam int CNT_W    = $clog2(NODES + 1);
  localparam int SYM_W    = $clog2(ALPHABET);
  localparam int HERE_W   = 16;
  localparam int TOT_W    = 32;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_SCAN  = 2'd2;

  typedef struct packed {
    logic [ALPHABET-1:0][NODE_W-1:0] child;
    logic [NODE_W-1:0]               parent;
    logic [SYM_W-1:0]                edge_sym;
    logic [HERE_W-1:0]               own;
    logic [HERE_W-1:0]               outc;
    logic [NODE_W-1:0]               fail;
  } node_t;

  typedef struct packed {
    logic              status;
    logic [HERE_W-1:0] here;
    logic [TOT_W-1:0]  total;
    logic              done;
  } res_t;

  function automatic logic [SYM_W-1:0] sym_mod(input logic [1:0] sym);
    logic [2:0] s3;
    s3 = {1'b0, sym};
    if (s3 >= 3'(ALPHABET)) begin
      s3 = s3 - 3'(ALPHABET);
    end
    return SYM_W'(s3);
  endfunction

endpackage

/* hdl/acm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module acm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hdl/acm_sat_add.sv */
// Shared saturating adder, 16-bit or 32-bit ceiling.
module acm_sat_add (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        wide_i,
  output logic [31:0] sum_o
);

  logic [32:0] s;

  always_comb begin
    s = {1'b0, a_i} + {1'b0, b_i};
    if (wide_i) begin
      sum_o = s[32] ? 32'hFFFF_FFFF : s[31:0];
    end else begin
      sum_o = (s > 33'h0_0000_FFFF) ? 32'h0000_FFFF : s[31:0];
    end
  end

endmodule

/* hdl/aho_corasick_matcher_unit.sv */
// Aho-Corasick matcher top level: sequencer over the node and walk-queue RAMs.
// Insert word: reads the cursor node, then adds a child, bumps a word count or steps down;
// scan word: one node read per failure hop, through the single node RAM read port.
// Build word: walks the trie breadth-first, following the failure chain per trie node.
// One word at a time; a finished result waits in the output register.
// Reset is asynchronous, active low; the trie comes up holding the root only.
module aho_corasick_matcher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] symbol, [7:2] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] matches_here, [47:16] match_total
  output logic        m_axis_tuser,   // [0] status
  output logic        m_axis_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_INS_RD, ST_INS_NEW, ST_INS_CNT, ST_B_POP, ST_B_ID, ST_B_REC,
    ST_B_PAR, ST_WALK, ST_B_F, ST_B_KIDS, ST_S_F, ST_EMIT
  } state_e;

  localparam int NW = acm_pkg::NODE_W;
  localparam int CW = acm_pkg::CNT_W;
  localparam int SW = acm_pkg::SYM_W;

  state_e              state_q, state_d;
  logic [SW-1:0]       sym_q, sym_d;
  logic                last_q, last_d;
  logic [NW-1:0]       cursor_q, cursor_d;
  logic                dropped_q, dropped_d;
  logic [CW-1:0]       count_q, count_d;
  logic [NW-1:0]       scan_q, scan_d;
  logic [31:0]         total_q, total_d;
  logic [CW-1:0]       head_q, head_d;
  logic [CW-1:0]       tail_q, tail_d;
  logic [NW-1:0]       id_q, id_d;
  acm_pkg::node_t      idrec_q, idrec_d;
  logic [NW-1:0]       walk_p_q, walk_p_d;
  logic [SW-1:0]       walk_c_q, walk_c_d;
  logic                walk_scan_q, walk_scan_d;
  logic [SW-1:0]       kid_q, kid_d;
  logic                root_ok_q, root_ok_d;
  logic                rd_zero_q, rd_zero_d;
  acm_pkg::res_t       res_q, res_d;
  acm_pkg::res_t       out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                nwe, nre, qwe, qre;
  logic [NW-1:0]       nwaddr, nraddr, qwaddr, qraddr, qwdata, qrdata;
  acm_pkg::node_t      nwdata, ram_rdata, rec;
  logic [31:0]         sat_a, sat_b, sat_sum;
  logic                sat_wide;
  logic [NW-1:0]       k;
  logic                accept;

  acm_ram #(.WIDTH($bits(acm_pkg::node_t)), .DEPTH(acm_pkg::NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (nwe),
    .waddr_i (nwaddr),
    .wdata_i (nwdata),
    .re_i    (nre),
    .raddr_i (nraddr),
    .rdata_o (ram_rdata)
  );

  acm_ram #(.WIDTH(NW), .DEPTH(acm_pkg::NODES)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (qwe),
    .waddr_i (qwaddr),
    .wdata_i (qwdata),
    .re_i    (qre),
    .raddr_i (qraddr),
    .rdata_o (qrdata)
  );

  acm_sat_add u_sat_add (
    .a_i    (sat_a),
    .b_i    (sat_b),
    .wide_i (sat_wide),
    .sum_o  (sat_sum)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rec           = (rd_zero_q && !root_ok_q) ? '0 : ram_rdata;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.total, out_q.here};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.done;

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    last_d      = last_q;
    cursor_d    = cursor_q;
    dropped_d   = dropped_q;
    count_d     = count_q;
    scan_d      = scan_q;
    total_d     = total_q;
    head_d      = head_q;
    tail_d      = tail_q;
    id_d        = id_q;
    idrec_d     = idrec_q;
    walk_p_d    = walk_p_q;
    walk_c_d    = walk_c_q;
    walk_scan_d = walk_scan_q;
    kid_d       = kid_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    nwe         = 1'b0;
    nre         = 1'b0;
    qwe         = 1'b0;
    qre         = 1'b0;
    nwaddr      = '0;
    nraddr      = '0;
    nwdata      = rec;
    qwaddr      = '0;
    qraddr      = '0;
    qwdata      = '0;
    sat_a       = '0;
    sat_b       = '0;
    sat_wide    = 1'b0;
    k           = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sym_d  = acm_pkg::sym_mod(s_axis_tdata[1:0]);
          last_d = s_axis_tlast;
          res_d  = '0;
          case (s_axis_tuser)
            acm_pkg::MODE_ADD: begin
              if (dropped_q) begin
                res_d.status = 1'b1;
                if (s_axis_tlast) begin
                  cursor_d  = '0;
                  dropped_d = 1'b0;
                end
                state_d = ST_EMIT;
              end else begin
                nre     = 1'b1;
                nraddr  = cursor_q;
                state_d = ST_INS_RD;
              end
            end
            acm_pkg::MODE_BUILD: begin
              qwe     = 1'b1;
              head_d  = '0;
              tail_d  = CW'(1);
              state_d = ST_B_POP;
            end
            acm_pkg::MODE_SCAN: begin
              walk_p_d    = scan_q;
              walk_c_d    = acm_pkg::sym_mod(s_axis_tdata[1:0]);
              walk_scan_d = 1'b1;
              nre         = 1'b1;
              nraddr      = scan_q;
              state_d     = ST_WALK;
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_INS_RD: begin
        k = rec.child[sym_q];
        if (k == '0) begin
          if (count_q == CW'(acm_pkg::NODES)) begin
            res_d.status = 1'b1;
            if (last_q) begin
              cursor_d  = '0;
              dropped_d = 1'b0;
            end else begin
              dropped_d = 1'b1;
            end
            state_d = ST_EMIT;
          end else begin
            nwdata              = rec;
            nwdata.child[sym_q] = count_q[NW-1:0];
            nwe                 = 1'b1;
            nwaddr              = cursor_q;
            id_d                = count_q[NW-1:0];
            count_d             = count_q + CW'(1);
            state_d             = ST_INS_NEW;
          end
        end else if (last_q) begin
          id_d    = k;
          nre     = 1'b1;
          nraddr  = k;
          state_d = ST_INS_CNT;
        end else begin
          cursor_d = k;
          state_d  = ST_EMIT;
        end
      end
      ST_INS_NEW: begin
        nwdata          = '0;
        nwdata.parent   = cursor_q;
        nwdata.edge_sym = sym_q;
        nwdata.own      = {{(acm_pkg::HERE_W-1){1'b0}}, last_q};
        nwe             = 1'b1;
        nwaddr          = id_q;
        cursor_d        = last_q ? '0 : id_q;
        state_d         = ST_EMIT;
      end
      ST_INS_CNT: begin
        sat_a      = {16'd0, rec.own};
        sat_b      = 32'd1;
        nwdata     = rec;
        nwdata.own = sat_sum[15:0];
        nwe        = 1'b1;
        nwaddr     = id_q;
        cursor_d   = '0;
        state_d    = ST_EMIT;
      end
      ST_B_POP: begin
        if (head_q == tail_q) begin
          state_d = ST_EMIT;
        end else begin
          qre     = 1'b1;
          qraddr  = head_q[NW-1:0];
          head_d  = head_q + CW'(1);
          state_d = ST_B_ID;
        end
      end
      ST_B_ID: begin
        id_d    = qrdata;
        nre     = 1'b1;
        nraddr  = qrdata;
        state_d = ST_B_REC;
      end
      ST_B_REC: begin
        idrec_d = rec;
        if (id_q == '0 || rec.parent == '0) begin
          idrec_d.fail = '0;
          idrec_d.outc = rec.own;
          nwdata       = idrec_d;
          nwe          = 1'b1;
          nwaddr       = id_q;
          kid_d        = '0;
          state_d      = ST_B_KIDS;
        end else begin
          nre     = 1'b1;
          nraddr  = rec.parent;
          state_d = ST_B_PAR;
        end
      end
      ST_B_PAR: begin
        walk_p_d    = rec.fail;
        walk_c_d    = idrec_q.edge_sym;
        walk_scan_d = 1'b0;
        nre         = 1'b1;
        nraddr      = rec.fail;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        k = rec.child[walk_c_q];
        if (walk_p_q != '0 && k == '0) begin
          walk_p_d = rec.fail;
          nre      = 1'b1;
          nraddr   = rec.fail;
        end else begin
          walk_p_d = (k != '0) ? k : walk_p_q;
          nre      = 1'b1;
          nraddr   = walk_p_d;
          state_d  = walk_scan_q ? ST_S_F : ST_B_F;
        end
      end
      ST_B_F: begin
        sat_a       = {16'd0, idrec_q.own};
        sat_b       = {16'd0, rec.outc};
        nwdata      = idrec_q;
        nwdata.fail = walk_p_q;
        nwdata.outc = sat_sum[15:0];
        nwe         = 1'b1;
        nwaddr      = id_q;
        kid_d       = '0;
        state_d     = ST_B_KIDS;
      end
      ST_B_KIDS: begin
        k = idrec_q.child[kid_q];
        if (k != '0 && tail_q < CW'(acm_pkg::NODES)) begin
          qwe    = 1'b1;
          qwaddr = tail_q[NW-1:0];
          qwdata = k;
          tail_d = tail_q + CW'(1);
        end
        if (kid_q == SW'(acm_pkg::ALPHABET - 1)) begin
          state_d = ST_B_POP;
        end else begin
          kid_d = kid_q + SW'(1);
        end
      end
      ST_S_F: begin
        sat_a      = total_q;
        sat_b      = {16'd0, rec.outc};
        sat_wide   = 1'b1;
        res_d.here  = rec.outc;
        res_d.total = sat_sum;
        res_d.done  = last_q;
        scan_d      = last_q ? '0 : walk_p_q;
        total_d     = last_q ? '0 : sat_sum;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign root_ok_d = root_ok_q || (nwe && nwaddr == '0);
  assign rd_zero_d = nre ? (nraddr == '0) : rd_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sym_q       <= '0;
      last_q      <= 1'b0;
      cursor_q    <= '0;
      dropped_q   <= 1'b0;
      count_q     <= CW'(1);
      scan_q      <= '0;
      total_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      id_q        <= '0;
      idrec_q     <= '0;
      walk_p_q    <= '0;
      walk_c_q    <= '0;
      walk_scan_q <= 1'b0;
      kid_q       <= '0;
      root_ok_q   <= 1'b0;
      rd_zero_q   <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sym_q       <= sym_d;
      last_q      <= last_d;
      cursor_q    <= cursor_d;
      dropped_q   <= dropped_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      total_q     <= total_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      id_q        <= id_d;
      idrec_q     <= idrec_d;
      walk_p_q    <= walk_p_d;
      walk_c_q    <= walk_c_d;
      walk_scan_q <= walk_scan_d;
      kid_q       <= kid_d;
      root_ok_q   <= root_ok_d;
      rd_zero_q   <= rd_zero_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= CW'(acm_pkg::NODES))
    else $error("node count out of range");
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("walk queue head passed tail");
  a_tail_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= count_q)
    else $error("walk queue holds more entries than nodes");
`endif

endmodule
